// File: design/tak_pkg.sv
package tak_pkg;

	typedef logic signed [31:0] q32_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 31;

	localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_NOISE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS_NOISE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MEAS_NOISE  = 3'd3;

	localparam logic [CFG_DATA_W-1:0] RST_TIME_STEP   = 31'd2684355;
	localparam logic [CFG_DATA_W-1:0] RST_ANGLE_NOISE = 31'd268435;
	localparam logic [CFG_DATA_W-1:0] RST_BIAS_NOISE  = 31'd805306;
	localparam logic [CFG_DATA_W-1:0] RST_MEAS_NOISE  = 31'd134217728;

	localparam q32_t ONE_Q28 = 32'sd268435456;

	// micro-operations of the shared multiplier
	typedef logic [3:0] op_t;
	localparam op_t OP_GYRO_DT = 4'd0;
	localparam op_t OP_DP00_DT = 4'd1;
	localparam op_t OP_P11_DT  = 4'd2;
	localparam op_t OP_BPN_DT  = 4'd3;
	localparam op_t OP_K1_P00  = 4'd4;
	localparam op_t OP_K1_P01  = 4'd5;
	localparam op_t OP_K0_P01  = 4'd6;
	localparam op_t OP_K0_P00  = 4'd7;
	localparam op_t OP_K0_ERR  = 4'd8;
	localparam op_t OP_K1_ERR  = 4'd9;

	typedef struct packed {
		logic load_in;
		logic mul_en;
		logic wb_en;
		op_t  op;
		logic prep;
		logic div_start;
		logic k_sel;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_full;
	} status_t;

	function automatic q32_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -40'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// drop 28 fraction bits, round half up
	function automatic logic signed [37:0] rnd28(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = v + 66'sd134217728;
		return t[65:28];
	endfunction

endpackage

// File: design/tak_div.sv
module tak_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tak_pkg::q32_t       dividend,
	input  logic signed [32:0]  divisor,
	output logic                done,
	output tak_pkg::q32_t       quotient
);
	import tak_pkg::*;

	logic        busy_q, fin_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q, den_q;
	logic [59:0] num_q;
	logic [31:0] mag;
	logic [34:0] trial;
	logic [30:0] sat;
	q32_t        quo_q;

	assign mag   = dividend[31] ? 32'(-dividend) : 32'(dividend);
	assign trial = {1'b0, rem_q, num_q[59]} - {2'b0, den_q};
	assign sat   = (|num_q[59:31]) ? 31'h7FFFFFFF : num_q[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (divisor[32] || divisor == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd59) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31];
			den_q <= divisor;
			num_q <= {mag, 28'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[32:0];
				num_q <= {num_q[58:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], num_q[59]};
				num_q <= {num_q[58:0], 1'b0};
			end
		end else if (fin_q) begin
			quo_q <= neg_q ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: design/tak_datapath.sv
module tak_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tak_pkg::cmd_t                           cmd,
	output tak_pkg::status_t                        status,
	input  logic                                    cfg_we,
	input  logic [tak_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [tak_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic [63:0]                             s_tdata,
	output logic [63:0]                             m_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready
);
	import tak_pkg::*;

	logic [30:0] dt_q, apn_q, bpn_q, mn_q;
	q32_t ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	q32_t accel_q, gyro_q, k0_q, k1_q;
	logic signed [32:0] err_q, e_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [33:0] dp;
	logic signed [39:0] r40;
	logic signed [37:0] r;
	logic        div_done;
	q32_t        div_q;
	logic        out_valid_q;
	logic [63:0] out_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q  <= RST_TIME_STEP;
			apn_q <= RST_ANGLE_NOISE;
			bpn_q <= RST_BIAS_NOISE;
			mn_q  <= RST_MEAS_NOISE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_STEP:   dt_q  <= cfg_data;
				REG_ANGLE_NOISE: apn_q <= cfg_data;
				REG_BIAS_NOISE:  bpn_q <= cfg_data;
				REG_MEAS_NOISE:  mn_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dp = 34'($signed({3'b0, apn_q})) - 34'(p01_q) - 34'(p10_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_GYRO_DT: begin
				mul_a = 33'(gyro_q) - 33'(bias_q);
				mul_b = $signed({2'b0, dt_q});
			end
			OP_DP00_DT: begin
				if (dp[33] != dp[32])
					mul_a = dp[33] ? {1'b1, 32'd0} : {1'b0, {32{1'b1}}};
				else
					mul_a = dp[32:0];
				mul_b = $signed({2'b0, dt_q});
			end
			OP_P11_DT: begin
				mul_a = 33'(p11_q);
				mul_b = $signed({2'b0, dt_q});
			end
			OP_BPN_DT: begin
				mul_a = $signed({2'b0, bpn_q});
				mul_b = $signed({2'b0, dt_q});
			end
			OP_K1_P00: begin mul_a = 33'(k1_q); mul_b = 33'(p00_q); end
			OP_K1_P01: begin mul_a = 33'(k1_q); mul_b = 33'(p01_q); end
			OP_K0_P01: begin mul_a = 33'(k0_q); mul_b = 33'(p01_q); end
			OP_K0_P00: begin mul_a = 33'(k0_q); mul_b = 33'(p00_q); end
			OP_K0_ERR: begin mul_a = 33'(k0_q); mul_b = err_q; end
			OP_K1_ERR: begin mul_a = 33'(k1_q); mul_b = err_q; end
			default: ;
		endcase
	end

	assign r   = rnd28(prod_q);
	assign r40 = 40'(r);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= 66'(mul_a) * 66'(mul_b);
		if (cmd.load_in) begin
			accel_q <= s_tdata[31:0];
			gyro_q  <= s_tdata[63:32];
		end
		if (cmd.prep) begin
			err_q <= 33'(accel_q) - 33'(ang_q);
			e_q   <= $signed({2'b0, mn_q}) + 33'(p00_q);
		end
		if (div_done) begin
			if (cmd.k_sel) k1_q <= div_q;
			else           k0_q <= div_q;
		end
		if (cmd.out_load) out_q <= {sat32(40'(gyro_q) - 40'(bias_q)), ang_q};
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= ONE_Q28;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= ONE_Q28;
		end else if (cmd.wb_en) begin
			case (cmd.op)
				OP_GYRO_DT: ang_q <= sat32(40'(ang_q) + r40);
				OP_DP00_DT: p00_q <= sat32(40'(p00_q) + r40);
				OP_P11_DT: begin
					p01_q <= sat32(40'(p01_q) - r40);
					p10_q <= sat32(40'(p10_q) - r40);
				end
				OP_BPN_DT: p11_q  <= sat32(40'(p11_q) + r40);
				OP_K1_P00: p10_q  <= sat32(40'(p10_q) - r40);
				OP_K1_P01: p11_q  <= sat32(40'(p11_q) - r40);
				OP_K0_P01: p01_q  <= sat32(40'(p01_q) - r40);
				OP_K0_P00: p00_q  <= sat32(40'(p00_q) - r40);
				OP_K0_ERR: ang_q  <= sat32(40'(ang_q) + r40);
				OP_K1_ERR: bias_q <= sat32(40'(bias_q) + r40);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	tak_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.k_sel ? p10_q : p00_q),
		.divisor  (e_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign status.div_done = div_done;
	assign status.out_full = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
endmodule

// File: design/tak_ctrl.sv
module tak_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tak_pkg::status_t  status,
	output tak_pkg::cmd_t     cmd
);
	import tak_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_WB   = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DIVW = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	op_t        op_q;
	logic       k_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_GYRO_DT;
			k_sel_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					op_q    <= OP_GYRO_DT;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					if (op_q == OP_BPN_DT) state_q <= S_PREP;
					else if (op_q == OP_K1_ERR) state_q <= S_OUT;
					else begin
						op_q    <= op_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_PREP: begin
					k_sel_q <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (status.div_done) begin
					if (k_sel_q) begin
						op_q    <= OP_K1_P00;
						state_q <= S_MUL;
					end else begin
						k_sel_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_OUT: if (!status.out_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.k_sel     = k_sel_q;
		cmd.load_in   = (state_q == S_IDLE) && s_tvalid;
		cmd.mul_en    = (state_q == S_MUL);
		cmd.wb_en     = (state_q == S_WB);
		cmd.prep      = (state_q == S_PREP);
		cmd.div_start = (state_q == S_DIV);
		cmd.out_load  = (state_q == S_OUT) && !status.out_full;
	end

	assign s_tready = (state_q == S_IDLE);
endmodule

// File: design/tilt_angle_kalman_filter_top.sv
// Two-state (angle, gyro bias) Kalman filter for tilt estimation. Each
// request on the slave side carries an accelerometer angle and a gyro rate
// (signed Q12.20); the block predicts, forms both gains with a serial divider,
// corrects angle, bias and the 2x2 covariance (Q4.28), and returns one
// request with the filtered angle and bias-corrected rate, both saturated.
// Ten multiply and write-back pairs run on one shared 33x33 multiplier and
// the two gains come from two 60-step restoring divisions. Items are
// handled one at a time; the result sits in an output register, so the
// next item is taken while it waits. Configuration registers (time step,
// angle and bias process noise, measurement noise, all unsigned Q3.28) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce;
// indexes beyond three are ignored.
module tilt_angle_kalman_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tak_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tak_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [63:0]                         s_tdata,  // accel_angle, gyro_rate
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [63:0]                         m_tdata   // filtered_angle, filtered_rate
);
	import tak_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence the filter steps
	tak_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// hold state, registers and arithmetic
	tak_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready)
	);

	// an accepted request closes the slave side until the result is staged
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten");

	// a staged result is visible in the next cycle
	a_out_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("staged result not presented");
endmodule

// File: test/tilt_angle_kalman_filter_top_tb.sv
`timescale 1ns / 1ps

module tilt_angle_kalman_filter_top_tb;
	import tak_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int SETTLE_CYCLES = 400;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [31:0] gyro_rate;
		logic signed [31:0] accel_angle;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] filtered_rate;
		logic signed [31:0] filtered_angle;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;	// accel_angle, gyro_rate
	logic m_tvalid;
	logic m_tready;
	logic [63:0] m_tdata;	// filtered_angle, filtered_rate

	tilt_angle_kalman_filter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// filter state mirrored by the predictor
	longint dt_q28, apn_q28, bpn_q28, mn_q28;
	longint angle_est, bias_est;
	longint cov [4];

	sample_t pending_samples [$];
	estimate_t expected_estimates [$];
	int mismatches;
	int checked;
	bit calm_phase;	// no idling near the end
	bit hold_off;	// long receiver stall
	int tx_gap;
	int rx_gap;
	int hold_cnt;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint clip32(longint v);
		return clip(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	// drop 28 fraction bits, round half up (arithmetic shift floors)
	function automatic longint round28(longint v);
		return (v + (64'sd1 <<< 27)) >>> 28;
	endfunction

	task automatic kalman_update(input sample_t smp);
		longint accel, gyro, ang, bias, d, err, den, k0, k1, t0, t1, dec;
		longint p00, p01, p10, p11;
		estimate_t est;
		accel = longint'(smp.accel_angle);
		gyro = longint'(smp.gyro_rate);
		p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
		k0 = 0; k1 = 0;
		// predict
		ang = clip32(angle_est + round28((gyro - bias_est) * dt_q28));
		d = clip(apn_q28 - p01 - p10, -64'sd4294967296, 64'sd4294967295);
		p00 = clip32(p00 + round28(d * dt_q28));
		dec = round28(p11 * dt_q28);
		p01 = clip32(p01 - dec);
		p10 = clip32(p10 - dec);
		p11 = clip32(p11 + round28(bpn_q28 * dt_q28));
		// correct; a non-positive denominator leaves the prediction as is
		err = accel - ang;
		den = mn_q28 + p00;
		if (den > 0) begin
			k0 = clip((p00 * (64'sd1 <<< 28)) / den, -64'sd2147483647, 64'sd2147483647);
			k1 = clip((p10 * (64'sd1 <<< 28)) / den, -64'sd2147483647, 64'sd2147483647);
		end
		t0 = p00; t1 = p01;
		p00 = clip32(p00 - round28(k0 * t0));
		p01 = clip32(p01 - round28(k0 * t1));
		p10 = clip32(p10 - round28(k1 * t0));
		p11 = clip32(p11 - round28(k1 * t1));
		ang = clip32(ang + round28(k0 * err));
		bias = clip32(bias_est + round28(k1 * err));
		angle_est = ang; bias_est = bias;
		cov[0] = p00; cov[1] = p01; cov[2] = p10; cov[3] = p11;
		est.filtered_angle = ang[31:0];
		est.filtered_rate = 32'(clip32(gyro - bias));
		expected_estimates.push_back(est);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 200 << 20)) - (100 << 20));
		endcase
	endfunction

	// driver: advance the request when accepted, idle in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				kalman_update(sample_t'(s_tdata));
				void'(pending_samples.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if ((s_tvalid && s_tready ? pending_samples.size() > 0 :
						pending_samples.size() > 0)) begin
					if (!calm_phase && $urandom_range(0, 7) == 0) begin
						tx_gap <= $urandom_range(0, 4);
						s_tvalid <= 1'b0;
					end else begin
						s_tvalid <= 1'b1;
						s_tdata <= pending_samples[0];
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: a long hold-off in its own process
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_off && hold_cnt < 2000) begin
			hold_cnt <= hold_cnt + 1;
		end
	end

	// monitor: compare each returned request with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		estimate_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = estimate_t'(m_tdata);
				if (expected_estimates.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result angle=%h rate=%h",
							got.filtered_angle, got.filtered_rate);
				end else begin
					want = expected_estimates.pop_front();
					checked <= checked + 1;
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("result %0d: angle exp %h got %h, rate exp %h got %h",
								checked, want.filtered_angle, got.filtered_angle,
								want.filtered_rate, got.filtered_rate);
					end
				end
			end
			if (hold_off && hold_cnt < 2000) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
				rx_gap <= $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// write one register with the block idle and mirror it
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIME_STEP: dt_q28 = longint'(val);
			REG_ANGLE_NOISE: apn_q28 = longint'(val);
			REG_BIAS_NOISE: bpn_q28 = longint'(val);
			REG_MEAS_NOISE: mn_q28 = longint'(val);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || expected_estimates.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		sample_t smp;
		for (int i = 0; i < n; i++) begin
			smp.accel_angle = rand_word();
			smp.gyro_rate = rand_word();
			pending_samples.push_back(smp);
		end
	endtask

	initial begin
		sample_t smp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm_phase = 1'b0;
		hold_off = 1'b0;
		mismatches = 0;
		checked = 0;
		dt_q28 = longint'(RST_TIME_STEP);
		apn_q28 = longint'(RST_ANGLE_NOISE);
		bpn_q28 = longint'(RST_BIAS_NOISE);
		mn_q28 = longint'(RST_MEAS_NOISE);
		angle_est = 0;
		bias_est = 0;
		cov[0] = longint'(ONE_Q28); cov[1] = 0; cov[2] = 0; cov[3] = longint'(ONE_Q28);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes under reset settings
		smp = '0;
		pending_samples.push_back(smp);
		smp.accel_angle = 32'sh7FFFFFFF; smp.gyro_rate = 32'sh7FFFFFFF;
		pending_samples.push_back(smp);
		smp.accel_angle = 32'sh80000000; smp.gyro_rate = 32'sh80000000;
		pending_samples.push_back(smp);
		smp.accel_angle = 32'sh7FFFFFFF; smp.gyro_rate = 32'sh80000000;
		pending_samples.push_back(smp);
		smp.accel_angle = -32'sd1; smp.gyro_rate = 32'sd1;
		pending_samples.push_back(smp);
		drain();

		// zero time step: prediction holds still
		write_reg(REG_TIME_STEP, 31'd0);
		queue_random(4);
		drain();

		// large noises and time step drive saturation and the zero-gain case
		write_reg(REG_TIME_STEP, 31'h7FFFFFFF);
		write_reg(REG_ANGLE_NOISE, 31'h7FFFFFFF);
		write_reg(REG_BIAS_NOISE, 31'h7FFFFFFF);
		write_reg(REG_MEAS_NOISE, 31'd1);
		queue_random(8);
		drain();

		write_reg(REG_ANGLE_NOISE, 31'd0);
		write_reg(REG_BIAS_NOISE, 31'd0);
		write_reg(REG_MEAS_NOISE, 31'h7FFFFFFF);
		write_reg(REG_TIME_STEP, 31'd1);
		queue_random(6);
		drain();

		// out-of-range index must be ignored
		write_reg(REG_UNUSED, 31'h12345678);
		write_reg(REG_TIME_STEP, RST_TIME_STEP);
		write_reg(REG_ANGLE_NOISE, RST_ANGLE_NOISE);
		write_reg(REG_BIAS_NOISE, RST_BIAS_NOISE);
		write_reg(REG_MEAS_NOISE, RST_MEAS_NOISE);

		// random with a long receiver stall while the sender keeps offering
		queue_random(RANDOM_ITEMS / 2);
		hold_off = 1'b1;
		drain();

		write_reg(REG_TIME_STEP, 31'($urandom_range(1, 31'h0FFFFFFF)));
		write_reg(REG_MEAS_NOISE, 31'($urandom_range(1, 31'h3FFFFFFF)));
		queue_random(RANDOM_ITEMS / 4);
		drain();

		calm_phase = 1'b1;
		queue_random(RANDOM_ITEMS / 4);
		drain();

		$display("Checked %0d filter results over six register settings,", checked);
		$display("including saturating inputs, zero time step and a long output stall.");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
